>>> src/frx_pkg.sv
// shared types and constants for the flow sequence receiver
// no dependencies; imported by frx_table and flow_sequence_receiver_unit
`timescale 1ns / 1ps
`default_nettype none

package frx_pkg;

  // number of tracked sender flows (1 to 8)
  localparam int unsigned Slots = 5;
  localparam int unsigned SlotIdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned SrcW = 48;
  localparam int unsigned SeqW = 32;
  localparam int unsigned SlotOutW = 3;

  // one datagram header
  typedef struct packed {
    logic [SrcW-1:0]        src_addr;
    logic signed [SeqW-1:0] chunk_no;
    logic                   last_part;
  } frx_req_t;

  // decision for one header
  typedef struct packed {
    logic                   ignored;
    logic [SlotOutW-1:0]    slot;
    logic                   deliver;
    logic                   send_ack;
    logic                   ended;
    logic signed [SeqW-1:0] seq_out;
  } frx_res_t;

  // low bits of a slot index, zero extended where the index is narrower
  function automatic logic [SlotOutW-1:0] slot_code(logic [SlotIdxW-1:0] idx);
    logic [SlotIdxW+SlotOutW-1:0] wide;
    wide = (SlotIdxW + SlotOutW)'(idx);
    return wide[SlotOutW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/frx_table.sv
// flow table: slot match, claim, sequence check and table update
// depends on frx_pkg
`timescale 1ns / 1ps
`default_nettype none

module frx_table (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire frx_pkg::frx_req_t req_i,
  output frx_pkg::frx_res_t     res_o
);
  import frx_pkg::*;

  logic [Slots-1:0]    free_q;
  logic [SrcW-1:0]     source_q [Slots];
  logic [SeqW-1:0]     count_q  [Slots];

  logic                hit, have_free, claim, ignored;
  logic [SlotIdxW-1:0] hit_idx, free_idx, pos;
  logic [SeqW-1:0]     base, expected;
  logic                deliver, ahead;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    have_free = 1'b0;
    free_idx = '0;
    // lowest occupied slot with the same source
    for (int i = 0; i < Slots; i++) begin
      if (!hit && !free_q[i] && (source_q[i] == req_i.src_addr)) begin
        hit     = 1'b1;
        hit_idx = SlotIdxW'(i);
      end
    end
    // highest free slot
    for (int i = 0; i < Slots; i++) begin
      if (free_q[i]) begin
        have_free = 1'b1;
        free_idx  = SlotIdxW'(i);
      end
    end
  end

  assign pos      = hit ? hit_idx : free_idx;
  assign claim    = !hit && have_free;
  assign ignored  = !hit && !have_free;
  assign base     = claim ? '0 : count_q[pos];
  assign expected = base + SeqW'(1);
  assign deliver  = !ignored && (req_i.chunk_no == $signed(expected));
  assign ahead    = req_i.chunk_no > $signed(expected);

  always_comb begin
    res_o.ignored  = ignored;
    res_o.slot     = ignored ? '0 : slot_code(pos);
    res_o.deliver  = deliver;
    res_o.send_ack = !ignored && !ahead;
    res_o.ended    = deliver && req_i.last_part;
    res_o.seq_out  = req_i.chunk_no;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
    end else if (fire_i) begin
      if (deliver && req_i.last_part) begin
        free_q[pos] <= 1'b1;
      end else if (claim) begin
        free_q[pos] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && !ignored) begin
      if (claim) begin
        source_q[pos] <= req_i.src_addr;
      end
      count_q[pos] <= deliver ? expected : base;
    end
  end

endmodule

`default_nettype wire

>>> src/flow_sequence_receiver_unit.sv
// top level of the flow sequence receiver: input register, flow table, result register
// depends on frx_pkg and frx_table
`timescale 1ns / 1ps
`default_nettype none

// Receive side of a stop-and-wait transfer tracking up to frx_pkg::Slots sender
// flows. Each header (source address and port, signed chunk number, last flag)
// is matched against the occupied slots; an unknown source claims the highest
// free slot with its count at zero, and with no free slot the header is
// ignored (slot 0, no ack). The expected chunk (count+1) is delivered and
// acknowledged and bumps the count, and a last chunk frees the slot; an older
// chunk is only acknowledged; a chunk further ahead is dropped without ack.
// Every header produces exactly one result item, in order. The item passes
// through the input register, then the result register; while the result is
// not stalled one item per cycle is sustained, since the table lookup, compare
// and update are combinational between the two registers. The input stall
// rises only while both registers are full and the result is stalled. Table
// storage needs no clearing pass: only the free flags reset.

module flow_sequence_receiver_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // input item channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [frx_pkg::SrcW-1:0]             src_addr_i,
  input  wire logic signed [frx_pkg::SeqW-1:0]      chunk_no_i,
  input  wire logic                                 last_part_i,
  // result item channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      ignored_o,
  output logic [frx_pkg::SlotOutW-1:0]              slot_o,
  output logic                                      deliver_o,
  output logic                                      send_ack_o,
  output logic                                      ended_o,
  output logic signed [frx_pkg::SeqW-1:0]           seq_out_o
);
  import frx_pkg::*;

  // input register
  logic     in_vld_q, in_vld_d;
  frx_req_t in_req_q;
  // result register
  logic     out_vld_q, out_vld_d;
  frx_res_t out_res_q;

  frx_res_t res;
  logic     in_take, fire, out_take;

  // the held item moves on when the result register is empty or draining
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_vld_q && !out_stall_i;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (out_take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q.src_addr  <= src_addr_i;
      in_req_q.chunk_no  <= chunk_no_i;
      in_req_q.last_part <= last_part_i;
    end
    if (fire) begin
      out_res_q <= res;
    end
  end

  // match, claim, sequence check and update of the flow table
  frx_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_req_q),
    .res_o  (res)
  );

  assign out_valid_o = out_vld_q;
  assign ignored_o   = out_res_q.ignored;
  assign slot_o      = out_res_q.slot;
  assign deliver_o   = out_res_q.deliver;
  assign send_ack_o  = out_res_q.send_ack;
  assign ended_o     = out_res_q.ended;
  assign seq_out_o   = out_res_q.seq_out;

  // an accepted item is always held in the input register next cycle
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_vld_q)
    else $error("accepted item not captured");

  // an ignored header never delivers, acknowledges or ends a flow
  a_ignored_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ignored_o |-> !deliver_o && !send_ack_o && !ended_o && slot_o == '0)
    else $error("ignored header has side effects");

  // a delivered chunk is always acknowledged; ending needs a delivery
  a_deliver_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (deliver_o || ended_o) |-> send_ack_o && deliver_o == 1'b1)
    else $error("delivery without ack");

  // a result moves into the register exactly when the held item fires
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q && out_res_q.seq_out == $past(in_req_q.chunk_no))
    else $error("result lost");

endmodule

`default_nettype wire
